[hdl/cpe_pkg.sv]
// shared types and constants for the coprime enumerator
package cpe_pkg;

  localparam int unsigned MaxModulus = 64;
  localparam int unsigned ModW       = 7;
  localparam int unsigned ValW       = 6;

  localparam logic [ModW-1:0] ModMax    = ModW'(MaxModulus);
  localparam logic [ModW-1:0] CandFirst = ModW'(2);
  localparam logic [ModW-1:0] ModOne    = ModW'(1);
  localparam logic [ValW-1:0] ValOne    = ValW'(1);

  typedef struct packed {
    logic [ModW-1:0] modulus;
    logic            first_half;
  } cpe_req_t;

  typedef struct packed {
    logic [ValW-1:0] coprime_value;
    logic            last;
  } cpe_res_t;

  typedef struct packed {
    logic            start;
    logic [ModW-1:0] dividend;
    logic [ModW-1:0] divisor;
  } cpe_rem_req_t;

  typedef struct packed {
    logic            done;
    logic [ModW-1:0] remainder;
  } cpe_rem_rsp_t;

endpackage

[hdl/cpe_rem_unit.sv]
// shift-subtract remainder unit, one dividend bit per cycle
module cpe_rem_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpe_pkg::cpe_rem_req_t req_i,
  output cpe_pkg::cpe_rem_rsp_t rsp_o
);
  import cpe_pkg::*;

  localparam int unsigned CntW = $clog2(ModW);
  localparam logic [CntW-1:0] CntLast = CntW'(ModW - 1);

  logic            active_q, active_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ModW-1:0] rem_q, rem_d;
  logic [ModW-1:0] shift_q, shift_d;
  logic [ModW-1:0] div_q, div_d;
  logic [ModW:0]   trial;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    shift_d  = shift_q;
    div_d    = div_q;
    trial    = {rem_q, shift_q[ModW-1]};
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = '0;
      rem_d    = '0;
      shift_d  = req_i.dividend;
      div_d    = req_i.divisor;
    end else if (active_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = ModW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[ModW-1:0];
      end
      shift_d = {shift_q[ModW-2:0], 1'b0};
      cnt_d   = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shift_q <= shift_d;
    div_q   <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

[hdl/coprime_enumerator_core.sv]
// coprime enumerator top level: candidate sequencer around the remainder unit
//
//   channel   signals                      handshake
//   request   req_i (modulus, first_half)  taken when start && !busy
//   result    result_o (value, last)       one cycle per word on result_valid_o
//
// the first word (1) appears in the cycle after acceptance; each candidate passes
// the next and test states, and each Euclid remainder step in the shared
// remainder unit runs seven bit steps plus start and hand-back.
// busy stays high until the cycle that shows the last word.
// reset clears the sequencer and the result strobe; the receiver cannot stall.
module coprime_enumerator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  cpe_pkg::cpe_req_t req_i,
  output logic              busy,
  output cpe_pkg::cpe_res_t result_o,
  output logic              result_valid_o
);
  import cpe_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StNext  = 3'd1;
  localparam logic [2:0] StTest  = 3'd2;
  localparam logic [2:0] StWait  = 3'd3;
  localparam logic [2:0] StFinal = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [ModW-1:0] mod_q, mod_d;
  logic [ModW-1:0] limit_q, limit_d;
  logic [ModW-1:0] cand_q, cand_d;
  logic [ModW-1:0] dvd_q, dvd_d;
  logic [ModW-1:0] dvs_q, dvs_d;
  cpe_res_t        res_q, res_d;
  logic            valid_q, valid_d;
  logic [ModW-1:0] mod_sat;
  logic [ModW-1:0] mod_dec;
  cpe_rem_req_t    rem_req;
  cpe_rem_rsp_t    rem_rsp;

  cpe_rem_unit u_rem (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (rem_req),
    .rsp_o (rem_rsp)
  );

  assign mod_sat = (req_i.modulus > ModMax) ? ModMax : req_i.modulus;
  assign mod_dec = mod_q - ModOne;

  always_comb begin
    state_d          = state_q;
    mod_d            = mod_q;
    limit_d          = limit_q;
    cand_d           = cand_q;
    dvd_d            = dvd_q;
    dvs_d            = dvs_q;
    res_d            = res_q;
    valid_d          = 1'b0;
    rem_req.start    = 1'b0;
    rem_req.dividend = dvd_q;
    rem_req.divisor  = dvs_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          mod_d = mod_sat;
          if (req_i.first_half) begin
            limit_d = (mod_sat >> 1) + ModOne;
          end else begin
            limit_d = (mod_sat >= ModOne) ? mod_sat - ModOne : '0;
          end
          cand_d              = CandFirst;
          res_d.coprime_value = ValOne;
          res_d.last          = 1'b0;
          valid_d             = 1'b1;
          state_d             = StNext;
        end
      end
      StNext: begin
        if (cand_q < limit_q) begin
          dvd_d   = mod_q;
          dvs_d   = cand_q;
          state_d = StTest;
        end else begin
          state_d = StFinal;
        end
      end
      StTest: begin
        if (dvs_q > ModOne) begin
          rem_req.start = 1'b1;
          state_d       = StWait;
        end else begin
          if (dvs_q == ModOne) begin
            res_d.coprime_value = cand_q[ValW-1:0];
            res_d.last          = 1'b0;
            valid_d             = 1'b1;
          end
          cand_d  = cand_q + ModOne;
          state_d = StNext;
        end
      end
      StWait: begin
        if (rem_rsp.done) begin
          dvd_d   = dvs_q;
          dvs_d   = rem_rsp.remainder;
          state_d = StTest;
        end
      end
      StFinal: begin
        res_d.coprime_value = mod_dec[ValW-1:0];
        res_d.last          = 1'b1;
        valid_d             = 1'b1;
        state_d             = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q   <= mod_d;
    limit_q <= limit_d;
    cand_q  <= cand_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    res_q   <= res_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_o       = res_q;
  assign result_valid_o = valid_q;

endmodule

[hdl/cpe_checker.sv]
// port-level checker for the coprime enumerator, bound to the top level
module cpe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input cpe_pkg::cpe_req_t req_i,
  input logic              busy,
  input cpe_pkg::cpe_res_t result_o,
  input logic              result_valid_o
);
  import cpe_pkg::*;

  logic req_seen;
  assign req_seen = (req_i.modulus != '1) || req_i.first_half || !req_i.first_half;

  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_seen) |=> (result_valid_o && busy &&
      result_o.coprime_value == ValOne && !result_o.last))
    else $error("first word after a request is not 1");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy)
    else $error("non-final word while idle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> !busy)
    else $error("final word while still busy");

  a_end_of_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && result_o.last))
    else $error("busy dropped without a final word");

endmodule

bind coprime_enumerator_core cpe_checker u_cpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .req_i         (req_i),
  .busy          (busy),
  .result_o      (result_o),
  .result_valid_o(result_valid_o)
);
